/* hdl/lgst_pkg.sv */
`default_nettype none

package lgst_pkg;

    // Gate geometry
    localparam int NUM_BEAMS   = 6;
    localparam int BEAM_IDX_W  = $clog2(NUM_BEAMS);
    localparam int IVL_DEPTH   = NUM_BEAMS - 1;
    localparam int IVL_IDX_W   = (IVL_DEPTH > 1) ? $clog2(IVL_DEPTH) : 1;
    localparam int REC_W       = $clog2(NUM_BEAMS + 1);

    // Field widths
    localparam int BEAM_W      = 3;
    localparam int TIME_W      = 32;
    localparam int SPACING_W   = 20;
    localparam int GAP_W       = 16;
    localparam int PAIR_W      = 3;
    localparam int SPEED_W     = 30;
    localparam int DIVIDEND_W  = 30;
    localparam int SCALE_W     = 10;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

    // um -> mm/s with time in us: speed = spacing_um * 1000 / dt_us
    localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(1000);

    // Stream packing
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 72;
    localparam int M_PAIR_LSB  = 0;
    localparam int M_IVL_LSB   = M_PAIR_LSB + PAIR_W;
    localparam int M_SPEED_LSB = M_IVL_LSB + TIME_W;
    localparam int M_VALID_BIT = M_SPEED_LSB + SPEED_W;
    localparam int M_USED_W    = M_VALID_BIT + 1;

    // Register map
    localparam int PADDR_W     = 3;
    localparam logic REG_SPACING = 1'b0;
    localparam logic REG_MIN_GAP = 1'b1;

    localparam logic STATUS_PAIR  = 1'b0;
    localparam logic STATUS_ABORT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_DIV,
        ST_PUSH
    } lgst_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } lgst_div_stat_t;

endpackage

`default_nettype wire

/* hdl/lgst_div.sv */
`default_nettype none

module lgst_div
    import lgst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [TIME_W-1:0]     divisor,
    output lgst_div_stat_t             stat,
    output logic      [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]     dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [TIME_W:0]       shifted;
    logic                  fits;

    // One quotient bit per cycle, restoring form; dividend bits shift out
    // the top of dq_reg while quotient bits shift in at the bottom.
    always_comb
    begin
        shifted   = {rem_reg, dq_reg[DIVIDEND_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? TIME_W'(shifted - {1'b0, dvs_reg}) : shifted[TIME_W-1:0];
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign stat.start = start;
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign quotient   = dq_reg;

endmodule

`default_nettype wire

/* hdl/light_gate_speed_timer_core.sv */
// Light-gate chronograph. Each input beat carries a beam index and the
// microsecond timestamp of its break. A break closer than min_gap_us to the
// previous accepted break of the same beam is dropped; beam indexes past the
// last beam are dropped too. Beam 0 starts a fresh session; each later beam
// is taken once and only in order. When the last beam breaks, the block
// sends one result beat per adjacent pair (interval in us and speed in mm/s,
// with speed_valid low and speed zero for a zero interval), tlast on the
// final pair, and ends the session. A last-beam break that arrives before
// the beam ahead of it was taken sends a single abort beat (tuser high, all
// data zero, tlast high) instead. A beat that produces no result passes
// through capture and evaluate only. A last-beam break runs one
// bit-serial divide per pair, one quotient bit per cycle, with a start
// step before and a push step after each divide; the push waits while
// the output side stalls. The input accepts the next beat as soon as the
// last result sits in the output register. Registers: beam_spacing_um at
// byte 0, min_gap_us at byte 4.

`default_nettype none

module light_gate_speed_timer_core
    import lgst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Break events; s_tdata: [2:0] beam, [34:3] time_us, rest zero
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,

    // Results; m_tdata: [2:0] pair, [34:3] interval_us, [64:35] speed_mm_s,
    // [65] speed_valid, rest zero; m_tuser: [0] status
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast,

    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    lgst_state_t state_reg, state_next;

    // Configuration registers
    logic [SPACING_W-1:0] spacing_reg, spacing_next;
    logic [GAP_W-1:0]     gap_reg, gap_next;
    logic                 cfg_wr;

    // Captured beat
    logic [BEAM_W-1:0]    beam_reg, beam_next;
    logic [TIME_W-1:0]    time_reg, time_next;

    // Per-beam debounce times
    logic [TIME_W-1:0]    lat_reg [NUM_BEAMS];
    logic [TIME_W-1:0]    lat_next [NUM_BEAMS];

    // Session: beams are always taken as a prefix, so a count and the
    // latest time are enough; the intervals are kept per pair.
    logic                 active_reg, active_next;
    logic [REC_W-1:0]     rec_cnt_reg, rec_cnt_next;
    logic [TIME_W-1:0]    prev_time_reg, prev_time_next;
    logic [TIME_W-1:0]    ivl_reg [IVL_DEPTH];
    logic [TIME_W-1:0]    ivl_next [IVL_DEPTH];

    logic [IVL_IDX_W-1:0] k_reg, k_next;
    logic                 abort_reg, abort_next;

    // Output register
    logic                 ovalid_reg, ovalid_next;
    logic                 ostatus_reg, ostatus_next;
    logic [PAIR_W-1:0]    opair_reg, opair_next;
    logic [TIME_W-1:0]    oivl_reg, oivl_next;
    logic [SPEED_W-1:0]   ospeed_reg, ospeed_next;
    logic                 osv_reg, osv_next;
    logic                 olast_reg, olast_next;

    // Divider hookup
    logic                  div_start;
    lgst_div_stat_t        div_stat;
    logic [DIVIDEND_W-1:0] div_quot;
    logic [DIVIDEND_W-1:0] dividend;

    // Evaluation helpers
    logic [BEAM_IDX_W-1:0] bidx;
    logic [TIME_W-1:0]     since_last;
    logic                  in_range;
    logic                  gap_ok;
    logic                  take_beam;
    logic                  out_free;
    logic [TIME_W-1:0]     cur_ivl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        spacing_next = spacing_reg;
        gap_next     = gap_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SPACING: spacing_next = pwdata[SPACING_W-1:0];
                REG_MIN_GAP: gap_next     = pwdata[GAP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SPACING: prdata = {{(32-SPACING_W){1'b0}}, spacing_reg};
            REG_MIN_GAP: prdata = {{(32-GAP_W){1'b0}}, gap_reg};
            default:     prdata = '0;
        endcase
    end

    // spacing * 1000 stays below 2^30, so the quotient never needs clamping
    assign dividend = DIVIDEND_W'(spacing_reg) * DIVIDEND_W'(SPEED_SCALE);

    lgst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (ivl_reg[k_reg]),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign bidx       = BEAM_IDX_W'(beam_reg);
    assign in_range   = 32'(beam_reg) < 32'(NUM_BEAMS);
    assign since_last = time_reg - lat_reg[bidx];
    assign gap_ok     = since_last >= TIME_W'(gap_reg);
    assign take_beam  = rec_cnt_reg == REC_W'(beam_reg);
    assign out_free   = !ovalid_reg || m_tready;
    assign cur_ivl    = ivl_reg[k_reg];

    always_comb
    begin
        state_next     = state_reg;
        beam_next      = beam_reg;
        time_next      = time_reg;
        lat_next       = lat_reg;
        active_next    = active_reg;
        rec_cnt_next   = rec_cnt_reg;
        prev_time_next = prev_time_reg;
        ivl_next       = ivl_reg;
        k_next         = k_reg;
        abort_next     = abort_reg;
        ovalid_next    = ovalid_reg;
        ostatus_next   = ostatus_reg;
        opair_next     = opair_reg;
        oivl_next      = oivl_reg;
        ospeed_next    = ospeed_reg;
        osv_next       = osv_reg;
        olast_next     = olast_reg;
        s_tready       = 1'b0;
        div_start      = 1'b0;

        // drop the held beat once the sink takes it
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    beam_next  = s_tdata[BEAM_W-1:0];
                    time_next  = s_tdata[BEAM_W +: TIME_W];
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                state_next = ST_IDLE;
                if (in_range && gap_ok)
                begin
                    lat_next[bidx] = time_reg;
                    if (beam_reg == '0)
                    begin
                        active_next    = 1'b1;
                        rec_cnt_next   = REC_W'(1);
                        prev_time_next = time_reg;
                    end
                    else if (active_reg)
                    begin
                        if (take_beam)
                        begin
                            ivl_next[IVL_IDX_W'(beam_reg - BEAM_W'(1))] =
                                time_reg - prev_time_reg;
                            prev_time_next = time_reg;
                            rec_cnt_next   = rec_cnt_reg + REC_W'(1);
                        end
                        if (32'(beam_reg) == 32'(NUM_BEAMS - 1))
                        begin
                            // session ends either way
                            active_next  = 1'b0;
                            rec_cnt_next = '0;
                            k_next       = '0;
                            abort_next   = !take_beam;
                            state_next   = take_beam ? ST_START : ST_PUSH;
                        end
                    end
                end
            end

            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (abort_reg)
                    begin
                        ostatus_next = STATUS_ABORT;
                        opair_next   = '0;
                        oivl_next    = '0;
                        ospeed_next  = '0;
                        osv_next     = 1'b0;
                        olast_next   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        ostatus_next = STATUS_PAIR;
                        opair_next   = PAIR_W'(k_reg);
                        oivl_next    = cur_ivl;
                        osv_next     = cur_ivl != '0;
                        ospeed_next  = (cur_ivl != '0) ? SPEED_W'(div_quot) : '0;
                        olast_next   = 32'(k_reg) == 32'(NUM_BEAMS - 2);
                        if (32'(k_reg) == 32'(NUM_BEAMS - 2))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next     = k_reg + IVL_IDX_W'(1);
                            state_next = ST_START;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            spacing_reg <= SPACING_W'(30000);
            gap_reg     <= GAP_W'(200);
            active_reg  <= 1'b0;
            rec_cnt_reg <= '0;
            ovalid_reg  <= 1'b0;
            for (int i = 0; i < NUM_BEAMS; i++)
            begin
                lat_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            spacing_reg <= spacing_next;
            gap_reg     <= gap_next;
            active_reg  <= active_next;
            rec_cnt_reg <= rec_cnt_next;
            ovalid_reg  <= ovalid_next;
            lat_reg     <= lat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beam_reg      <= beam_next;
        time_reg      <= time_next;
        prev_time_reg <= prev_time_next;
        ivl_reg       <= ivl_next;
        k_reg         <= k_next;
        abort_reg     <= abort_next;
        ostatus_reg   <= ostatus_next;
        opair_reg     <= opair_next;
        oivl_reg      <= oivl_next;
        ospeed_reg    <= ospeed_next;
        osv_reg       <= osv_next;
        olast_reg     <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ostatus_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, osv_reg, ospeed_reg, oivl_reg, opair_reg};

endmodule

`default_nettype wire

/* hdl/lgst_checker.sv */
`default_nettype none

module lgst_checker
    import lgst_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser,
    input wire logic                 m_tlast
);

    // a stalled result beat stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // an abort ends the run on its own beat
    a_abort_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("abort beat without tlast");

    // an abort carries no measurement
    a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("abort beat with nonzero data");

    // a valid speed needs a nonzero interval
    a_valid_ivl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[M_VALID_BIT] |-> m_tdata[M_IVL_LSB +: TIME_W] != '0)
        else $error("speed_valid with zero interval");

    // no speed without a valid flag
    a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[M_VALID_BIT] |-> m_tdata[M_SPEED_LSB +: SPEED_W] == '0)
        else $error("speed reported without speed_valid");

endmodule

bind light_gate_speed_timer_core lgst_checker u_lgst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
